[hdl/dasp_pkg.sv]
package dasp_pkg;

   localparam int DEFAULT_NUM_AXES    = 2;
   localparam int DEFAULT_COUNT_WIDTH = 32;

   localparam int CMD_WIDTH   = 2;
   localparam int PULSE_WIDTH = 32;
   localparam int RATE_WIDTH  = 24;
   localparam int TIMER_WIDTH = 27;

   localparam logic [TIMER_WIDTH-1:0] TIMER_RESET = TIMER_WIDTH'(1000000);
   localparam logic [TIMER_WIDTH-1:0] MIN_PERIOD  = TIMER_WIDTH'(2);

   // Words held between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    axis;
      logic                    axis_ok;
      logic                    dir;
      logic [PULSE_WIDTH-1:0]  count;
      logic [RATE_WIDTH-1:0]   rate;
      logic                    start_ok;
   } queue_word_type;

   typedef struct packed {
      logic                    start_accepted;
      logic                    step_x;
      logic                    dir_x;
      logic                    step_y;
      logic                    dir_y;
      logic                    busy_x;
      logic                    busy_y;
      logic                    done_x;
      logic                    done_y;
      logic [PULSE_WIDTH-1:0]  remaining;
   } rsp_word_type;

endpackage

[hdl/dasp_req_if.sv]
interface dasp_req_if import dasp_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [CMD_WIDTH-1:0]    cmd;
   logic                    axis;
   logic                    move_direction;
   logic [PULSE_WIDTH-1:0]  pulse_count;
   logic [RATE_WIDTH-1:0]   step_rate_hz;

   modport source (
      output valid, cmd, axis, move_direction, pulse_count, step_rate_hz,
      input  ready
   );

   modport sink (
      input  valid, cmd, axis, move_direction, pulse_count, step_rate_hz,
      output ready
   );

endinterface

[hdl/dasp_rsp_if.sv]
interface dasp_rsp_if import dasp_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic                    start_accepted;
   logic                    step_x;
   logic                    dir_x;
   logic                    step_y;
   logic                    dir_y;
   logic                    busy_x;
   logic                    busy_y;
   logic                    done_x;
   logic                    done_y;
   logic [PULSE_WIDTH-1:0]  remaining;

   modport source (
      output valid, start_accepted, step_x, dir_x, step_y, dir_y,
             busy_x, busy_y, done_x, done_y, remaining,
      input  ready
   );

   modport sink (
      input  valid, start_accepted, step_x, dir_x, step_y, dir_y,
             busy_x, busy_y, done_x, done_y, remaining,
      output ready
   );

endinterface

[hdl/dasp_front.sv]
module dasp_front import dasp_pkg::*; #(
   parameter int NUM_AXES    = DEFAULT_NUM_AXES,
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   dasp_req_if.sink        req_chan,
   output queue_word_type  head_word,
   output logic            head_valid,
   input  logic            head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_word_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   queue_word_type          word;
   logic [COUNT_WIDTH-1:0]  count_trunc;
   logic                    push;
   logic                    pop;

   // Classify the incoming word: truncate the count and precompute the
   // checks that do not depend on axis state.
   always_comb begin
      count_trunc   = req_chan.pulse_count[COUNT_WIDTH-1:0];
      word.cmd      = cmd_type'(req_chan.cmd);
      word.axis     = req_chan.axis;
      word.axis_ok  = (int'(req_chan.axis) < NUM_AXES);
      word.dir      = req_chan.move_direction;
      word.count    = PULSE_WIDTH'(count_trunc);
      word.rate     = req_chan.step_rate_hz;
      word.start_ok = word.axis_ok && (count_trunc != '0) && (req_chan.step_rate_hz != '0);
   end

   assign req_chan.ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid     = (fill_ff != '0);
   assign head_word      = slot_ff[rd_ptr_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

[hdl/dasp_back.sv]
module dasp_back import dasp_pkg::*; #(
   parameter int NUM_AXES    = DEFAULT_NUM_AXES,
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [TIMER_WIDTH-1:0]  csr_wr_data,
   input  queue_word_type          head_word,
   input  logic                    head_valid,
   output logic                    head_pop,
   dasp_rsp_if.source              rsp_chan
);

   // At least two axes of state so that both pin pairs always have a source;
   // an axis beyond NUM_AXES is never addressed and stays idle.
   localparam int STATE_AXES = (NUM_AXES < 2) ? 2 : NUM_AXES;
   localparam int DIV_CNT_W  = $clog2(TIMER_WIDTH + 1);

   typedef enum logic [1:0] {
      ST_RUN    = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [TIMER_WIDTH-1:0]    timer_ff;

   logic [STATE_AXES-1:0]     busy_ff, busy_in;
   logic [STATE_AXES-1:0]     done_ff, done_in;
   logic [STATE_AXES-1:0]     dir_ff, dir_in;
   logic [COUNT_WIDTH-1:0]    target_ff [STATE_AXES];
   logic [COUNT_WIDTH-1:0]    target_in [STATE_AXES];
   logic [COUNT_WIDTH-1:0]    emitted_ff [STATE_AXES];
   logic [COUNT_WIDTH-1:0]    emitted_in [STATE_AXES];
   logic [TIMER_WIDTH-1:0]    period_ff [STATE_AXES];
   logic [TIMER_WIDTH-1:0]    period_in [STATE_AXES];
   logic [TIMER_WIDTH-1:0]    phase_ff [STATE_AXES];
   logic [TIMER_WIDTH-1:0]    phase_in [STATE_AXES];

   // Restoring divider: the dividend shifts out of the top while quotient
   // bits shift in at the bottom.
   logic [TIMER_WIDTH-1:0]    dvd_ff, dvd_in;
   logic [RATE_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [RATE_WIDTH:0]       rem_shift;
   logic [RATE_WIDTH:0]       rate_ext;

   logic                      out_valid_ff, out_valid_in;
   rsp_word_type              rsp_ff, rsp_in;

   logic                      can_emit;
   logic                      commit;
   logic                      head_busy;
   logic                      need_div;
   logic                      start_go;
   logic [STATE_AXES-1:0]     sel;

   assign can_emit  = !out_valid_ff || rsp_chan.ready;
   assign rem_shift = {rem_ff, dvd_ff[TIMER_WIDTH-1]};
   assign rate_ext  = {1'b0, head_word.rate};

   always_comb begin
      head_busy = 1'b0;
      for (int a = 0; a < STATE_AXES; a++) begin
         sel[a] = head_word.axis_ok && (int'(head_word.axis) == a);
         if (sel[a]) begin
            head_busy = busy_ff[a];
         end
      end
      need_div = (head_word.cmd == CMD_START) && head_word.start_ok && !head_busy;
   end

   // Sequencer: one word per cycle while the output register can take a response, except a
   // start that passes the static checks on an idle axis, which first runs the divider.
   always_comb begin
      state_in   = state_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      commit     = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (head_valid && can_emit) begin
               if (need_div) begin
                  dvd_in     = timer_ff;
                  rem_in     = '0;
                  div_cnt_in = DIV_CNT_W'(TIMER_WIDTH);
                  state_in   = ST_DIVIDE;
               end else begin
                  commit = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_cnt_ff != '0) begin
               div_cnt_in = div_cnt_ff - 1'b1;
               if (rem_shift >= rate_ext) begin
                  rem_in = RATE_WIDTH'(rem_shift - rate_ext);
                  dvd_in = {dvd_ff[TIMER_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in = rem_shift[RATE_WIDTH-1:0];
                  dvd_in = {dvd_ff[TIMER_WIDTH-2:0], 1'b0};
               end
            end else if (can_emit) begin
               commit   = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign head_pop = commit;
   assign start_go = (state_ff == ST_DIVIDE) && (dvd_ff >= MIN_PERIOD);

   // Apply the word at the head of the queue to the axis state.
   always_comb begin
      logic [TIMER_WIDTH-1:0] phase_nx;
      logic [COUNT_WIDTH-1:0] emitted_nx;
      logic [COUNT_WIDTH-1:0] rem_cnt;
      busy_in = busy_ff;
      done_in = done_ff;
      dir_in  = dir_ff;
      rem_cnt = '0;
      for (int a = 0; a < STATE_AXES; a++) begin
         target_in[a]  = target_ff[a];
         emitted_in[a] = emitted_ff[a];
         period_in[a]  = period_ff[a];
         phase_in[a]   = phase_ff[a];
         phase_nx      = phase_ff[a] + 1'b1;
         emitted_nx    = emitted_ff[a] + 1'b1;
         if (commit) begin
            case (head_word.cmd)
               CMD_TICK: begin
                  if (busy_ff[a]) begin
                     if (phase_nx >= period_ff[a]) begin
                        phase_in[a]   = '0;
                        emitted_in[a] = emitted_nx;
                        if (emitted_nx >= target_ff[a]) begin
                           busy_in[a] = 1'b0;
                           done_in[a] = 1'b1;
                        end
                     end else begin
                        phase_in[a] = phase_nx;
                     end
                  end
               end
               CMD_START: begin
                  if (sel[a] && start_go) begin
                     busy_in[a]    = 1'b1;
                     done_in[a]    = 1'b0;
                     dir_in[a]     = head_word.dir;
                     target_in[a]  = head_word.count[COUNT_WIDTH-1:0];
                     emitted_in[a] = '0;
                     period_in[a]  = dvd_ff;
                     phase_in[a]   = '0;
                  end
               end
               CMD_STOP: begin
                  if (sel[a]) begin
                     busy_in[a]    = 1'b0;
                     done_in[a]    = 1'b0;
                     target_in[a]  = '0;
                     emitted_in[a] = '0;
                     phase_in[a]   = '0;
                  end
               end
               CMD_CLEAR: begin
                  if (sel[a]) begin
                     done_in[a] = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (sel[a] && busy_in[a]) begin
            rem_cnt = target_in[a] - emitted_in[a];
         end
      end

      rsp_in.start_accepted = (head_word.cmd == CMD_START) && start_go;
      rsp_in.step_x    = busy_in[0] && (phase_in[0] < (period_in[0] >> 1));
      rsp_in.dir_x     = dir_in[0];
      rsp_in.step_y    = busy_in[1] && (phase_in[1] < (period_in[1] >> 1));
      rsp_in.dir_y     = dir_in[1];
      rsp_in.busy_x    = busy_in[0];
      rsp_in.busy_y    = busy_in[1];
      rsp_in.done_x    = done_in[0];
      rsp_in.done_y    = done_in[1];
      rsp_in.remaining = PULSE_WIDTH'(rem_cnt);
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (commit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         timer_ff     <= TIMER_RESET;
         busy_ff      <= '0;
         done_ff      <= '0;
         dir_ff       <= '0;
         out_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         dir_ff       <= dir_in;
         out_valid_ff <= out_valid_in;
         div_cnt_ff   <= div_cnt_in;
         if (csr_wr_en) begin
            timer_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      for (int a = 0; a < STATE_AXES; a++) begin
         target_ff[a]  <= target_in[a];
         emitted_ff[a] <= emitted_in[a];
         period_ff[a]  <= period_in[a];
         phase_ff[a]   <= phase_in[a];
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.start_accepted = rsp_ff.start_accepted;
   assign rsp_chan.step_x         = rsp_ff.step_x;
   assign rsp_chan.dir_x          = rsp_ff.dir_x;
   assign rsp_chan.step_y         = rsp_ff.step_y;
   assign rsp_chan.dir_y          = rsp_ff.dir_y;
   assign rsp_chan.busy_x         = rsp_ff.busy_x;
   assign rsp_chan.busy_y         = rsp_ff.busy_y;
   assign rsp_chan.done_x         = rsp_ff.done_x;
   assign rsp_chan.done_y         = rsp_ff.done_y;
   assign rsp_chan.remaining      = rsp_ff.remaining;

endmodule

[hdl/dual_axis_step_pulse_generator_top.sv]
// Two-axis step/direction pulse generator. Each request word is a tick, a
// start, a stop or a clear-done command, and each one returns exactly one
// response word with the pin levels, busy and done flags of both axes and the
// pulses still to emit on the addressed axis. Tick, stop, clear and start words
// that fail the static or busy checks skip the divider, so ticks stream at one
// word per cycle while the output register can take a response. A tick's request
// is registered in the queue and its response in the output register. A start
// that has a free axis and a nonzero count and rate first loads the divider, then
// runs the one-bit-per-cycle divider that turns the timer clock into a step period,
// and then commits. A two-word queue sits between the front end and the back end,
// so requests keep entering while a division runs. Each response is held in an
// output register until it is taken. The back end holds the next word while that
// register is full and not being read.
module dual_axis_step_pulse_generator_top import dasp_pkg::*; #(
   parameter int NUM_AXES    = DEFAULT_NUM_AXES,
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   dasp_req_if.sink                req_chan,
   dasp_rsp_if.source              rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [TIMER_WIDTH-1:0]  csr_wr_data
);

   queue_word_type  head_word;
   logic            head_valid;
   logic            head_pop;

   dasp_front #(
      .NUM_AXES    (NUM_AXES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_word  (head_word),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   dasp_back #(
      .NUM_AXES    (NUM_AXES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_word   (head_word),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

[test/dasp_step_checker.sv]
`timescale 1ns / 1ps

module dasp_step_checker import dasp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   dasp_req_if                     req_mon,
   dasp_rsp_if                     rsp_mon,
   input  logic                    csr_wr_en,
   input  logic [TIMER_WIDTH-1:0]  csr_wr_data,
   output int unsigned             mismatches,
   output int unsigned             words_outstanding
);

   localparam int AXES = 2;

   logic [TIMER_WIDTH-1:0]  timer_hz;
   logic                    busy    [AXES];
   logic                    done    [AXES];
   logic                    dir     [AXES];
   logic [PULSE_WIDTH-1:0]  target  [AXES];
   logic [PULSE_WIDTH-1:0]  emitted [AXES];
   logic [31:0]             period  [AXES];
   logic [31:0]             phase   [AXES];

   rsp_word_type            expected_words[$];
   rsp_word_type            want;
   int unsigned             fail_count;
   int unsigned             words_checked;

   // Applies one command word to the axis state and returns the response word.
   function automatic rsp_word_type apply_command(cmd_type c, logic a, logic d,
                                                  logic [PULSE_WIDTH-1:0] count,
                                                  logic [RATE_WIDTH-1:0] rate);
      rsp_word_type w;
      logic [31:0]  per;
      w = '0;
      case (c)
         CMD_TICK: begin
            for (int i = 0; i < AXES; i++) begin
               if (busy[i]) begin
                  phase[i] = phase[i] + 32'd1;
                  if (phase[i] >= period[i]) begin
                     phase[i]   = '0;
                     emitted[i] = emitted[i] + 1'b1;
                     if (emitted[i] >= target[i]) begin
                        busy[i] = 1'b0;
                        done[i] = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_START: begin
            if (!busy[a] && count != '0 && rate != '0) begin
               per = 32'(timer_hz) / 32'(rate);
               if (per >= 32'(MIN_PERIOD)) begin
                  busy[a]    = 1'b1;
                  done[a]    = 1'b0;
                  dir[a]     = d;
                  target[a]  = count;
                  emitted[a] = '0;
                  period[a]  = per;
                  phase[a]   = '0;
                  w.start_accepted = 1'b1;
               end
            end
         end
         CMD_STOP: begin
            // The direction pin keeps its level on an abort.
            busy[a]    = 1'b0;
            done[a]    = 1'b0;
            target[a]  = '0;
            emitted[a] = '0;
            phase[a]   = '0;
         end
         default: begin
            done[a] = 1'b0;
         end
      endcase
      w.step_x    = busy[0] && (phase[0] < (period[0] >> 1));
      w.step_y    = busy[1] && (phase[1] < (period[1] >> 1));
      w.dir_x     = dir[0];
      w.dir_y     = dir[1];
      w.busy_x    = busy[0];
      w.busy_y    = busy[1];
      w.done_x    = done[0];
      w.done_y    = done[1];
      w.remaining = busy[a] ? target[a] - emitted[a] : '0;
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [PULSE_WIDTH-1:0] got,
                                  logic [PULSE_WIDTH-1:0] exp_val);
      if (fail_count < 40) begin
         $display("word %0d: %s is %0h, predicted %0h", words_checked, what, got,
                  exp_val);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timer_hz = TIMER_RESET;
         for (int i = 0; i < AXES; i++) begin
            busy[i]    = 1'b0;
            done[i]    = 1'b0;
            dir[i]     = 1'b0;
            target[i]  = '0;
            emitted[i] = '0;
            period[i]  = '0;
            phase[i]   = '0;
         end
         expected_words.delete();
         fail_count    = 0;
         words_checked = 0;
      end else begin
         if (csr_wr_en) begin
            timer_hz = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_words.push_back(apply_command(cmd_type'(req_mon.cmd), req_mon.axis,
                                                   req_mon.move_direction,
                                                   req_mon.pulse_count,
                                                   req_mon.step_rate_hz));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, remaining", rsp_mon.remaining, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.start_accepted !== want.start_accepted)
                  report_mismatch("start_accepted", rsp_mon.start_accepted,
                                  want.start_accepted);
               if (rsp_mon.step_x !== want.step_x)
                  report_mismatch("step_x", rsp_mon.step_x, want.step_x);
               if (rsp_mon.dir_x !== want.dir_x)
                  report_mismatch("dir_x", rsp_mon.dir_x, want.dir_x);
               if (rsp_mon.step_y !== want.step_y)
                  report_mismatch("step_y", rsp_mon.step_y, want.step_y);
               if (rsp_mon.dir_y !== want.dir_y)
                  report_mismatch("dir_y", rsp_mon.dir_y, want.dir_y);
               if (rsp_mon.busy_x !== want.busy_x)
                  report_mismatch("busy_x", rsp_mon.busy_x, want.busy_x);
               if (rsp_mon.busy_y !== want.busy_y)
                  report_mismatch("busy_y", rsp_mon.busy_y, want.busy_y);
               if (rsp_mon.done_x !== want.done_x)
                  report_mismatch("done_x", rsp_mon.done_x, want.done_x);
               if (rsp_mon.done_y !== want.done_y)
                  report_mismatch("done_y", rsp_mon.done_y, want.done_y);
               if (rsp_mon.remaining !== want.remaining)
                  report_mismatch("remaining", rsp_mon.remaining, want.remaining);
            end
            words_checked++;
         end
      end
      mismatches        <= fail_count;
      words_outstanding <= expected_words.size();
   end

endmodule

[test/dual_axis_step_pulse_generator_top_tb.sv]
`timescale 1ns / 1ps

module dual_axis_step_pulse_generator_top_tb import dasp_pkg::*; ();

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [TIMER_WIDTH-1:0]  csr_wr_data;
   logic [TIMER_WIDTH-1:0]  clock_hz;
   bit                      quiet;
   int unsigned             mismatches;
   int unsigned             words_outstanding;

   dasp_req_if req_chan ();
   dasp_rsp_if rsp_chan ();

   dual_axis_step_pulse_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dasp_step_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (mismatches),
      .words_outstanding (words_outstanding)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= quiet || ($urandom_range(99) >= 35);
      end
   end

   // Valid stays high from one word to the next unless the sender idles.
   task automatic send_word(cmd_type c, logic a, logic d, logic [PULSE_WIDTH-1:0] count,
                            logic [RATE_WIDTH-1:0] rate);
      while (!quiet && $urandom_range(99) < 35) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.cmd            <= c;
      req_chan.axis           <= a;
      req_chan.move_direction <= d;
      req_chan.pulse_count    <= count;
      req_chan.step_rate_hz   <= rate;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Holds the sender off until every response has come back.
   task automatic drain(int extra);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_timer(logic [TIMER_WIDTH-1:0] value);
      drain(32);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      clock_hz    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Rate that gives a step period of about p timer ticks at the current clock.
   function automatic logic [RATE_WIDTH-1:0] rate_for(int unsigned p);
      logic [31:0] r;
      r = 32'(clock_hz) / p;
      if (r > 32'h00FF_FFFF) r = 32'h00FF_FFFF;
      if (r == 0) r = 1;
      return r[RATE_WIDTH-1:0];
   endfunction

   task automatic random_word();
      int unsigned            roll;
      int unsigned            pick;
      logic [PULSE_WIDTH-1:0] count;
      logic [RATE_WIDTH-1:0]  rate;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      if (roll < 62) begin
         send_word(CMD_TICK, 1'($urandom), 1'($urandom), $urandom, 24'($urandom));
      end else if (roll < 84) begin
         if (pick < 85) count = $urandom_range(4, 1);
         else if (pick < 93) count = $urandom;
         else count = '0;
         pick = $urandom_range(99);
         if (pick < 80) rate = rate_for($urandom_range(12, 2));
         else if (pick < 90) rate = 24'($urandom);
         else if (pick < 95) rate = '0;
         else rate = 24'hFF_FFFF;
         send_word(CMD_START, 1'($urandom), 1'($urandom), count, rate);
      end else if (roll < 92) begin
         send_word(CMD_STOP, 1'($urandom), 1'($urandom), $urandom, 24'($urandom));
      end else begin
         send_word(CMD_CLEAR, 1'($urandom), 1'($urandom), $urandom, 24'($urandom));
      end
   endtask

   initial begin
      logic [TIMER_WIDTH-1:0] phase_hz [7];
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.cmd            <= CMD_TICK;
      req_chan.axis           <= 1'b0;
      req_chan.move_direction <= 1'b0;
      req_chan.pulse_count    <= '0;
      req_chan.step_rate_hz   <= '0;
      clock_hz = TIMER_RESET;
      quiet    = 1'b0;
      phase_hz = '{27'd64, 27'd0, 27'd100_000_000, 27'd1, 27'd3000,
                   27'($urandom_range(100_000_000, 2)), TIMER_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset clock of 1 MHz.
      send_word(CMD_TICK, 1'b0, 1'b1, '1, '1);
      send_word(CMD_TICK, 1'b1, 1'b0, '0, '0);
      send_word(CMD_START, 1'b0, 1'b1, 32'd2, 24'd250_000);
      send_word(CMD_START, 1'b0, 1'b0, 32'd5, 24'd250_000);
      send_word(CMD_START, 1'b1, 1'b1, 32'd0, 24'd1000);
      send_word(CMD_START, 1'b1, 1'b1, 32'd4, 24'd0);
      send_word(CMD_START, 1'b1, 1'b1, 32'd4, 24'hFF_FFFF);
      send_word(CMD_START, 1'b1, 1'b1, 32'd4, 24'd500_001);
      send_word(CMD_START, 1'b1, 1'b1, 32'hFFFF_FFFF, 24'd500_000);
      for (int i = 0; i < 8; i++) begin
         send_word(CMD_TICK, 1'(i), 1'b0, '0, '0);
      end
      send_word(CMD_STOP, 1'b1, 1'b0, '0, '0);
      send_word(CMD_CLEAR, 1'b0, 1'b0, '0, '0);
      send_word(CMD_STOP, 1'b0, 1'b0, '0, '0);
      send_word(CMD_CLEAR, 1'b1, 1'b0, '0, '0);
      send_word(CMD_START, 1'b1, 1'b0, 32'd1, 24'd1);
      send_word(CMD_STOP, 1'b1, 1'b1, '0, '0);

      foreach (phase_hz[p]) begin
         write_timer(phase_hz[p]);
         quiet = (p == 2);
         for (int i = 0; i < 215; i++) begin
            if (p == 3 && i == 100) begin
               drain(0);
            end
            random_word();
         end
      end
      quiet = 1'b0;

      drain(40);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(12 * 600_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

[dual_axis_step_pulse_generator_top.f]
hdl/dasp_pkg.sv
hdl/dasp_req_if.sv
hdl/dasp_rsp_if.sv
hdl/dasp_front.sv
hdl/dasp_back.sv
hdl/dual_axis_step_pulse_generator_top.sv
test/dasp_step_checker.sv
test/dual_axis_step_pulse_generator_top_tb.sv
